@@ hdl/vfcm_pkg.sv @@
// ----------------------------------------------------------------------------
// vfcm_pkg
// shared types, codes and tables of the voxel face culling mesher
// ----------------------------------------------------------------------------
`default_nettype none

package vfcm_pkg;

   localparam int GRID_XY_DEFAULT = 16;
   localparam int GRID_Z_DEFAULT  = 64;

   localparam logic [10:0] VOXEL_SIZE_RESET = 11'd100;

   // request kinds
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_MESH  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [2:0] LAST_FACE  = 3'd5;
   localparam logic [2:0] LAST_STEP  = 3'd6;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_CHECK,
      ST_EMIT
   } vfcm_state_type;

   // controller to datapath
   typedef struct packed {
      logic       clr_step;
      logic       capture;
      logic       mem_write;
      logic       cnt_clear;
      logic       rd_issue;
      logic [2:0] rd_step;
      logic       emit;
      logic [2:0] face;
      logic [1:0] corner;
      logic       last;
   } vfcm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       clr_last;
      logic       req_valid;
      logic [1:0] req_kind;
      logic       req_in_grid;
      logic       self_solid;
      logic [5:0] exposed;
      logic       out_free;
   } vfcm_status_type;

   // corner sign bits per face and corner: bit0 +x, bit1 +y, bit2 +z
   function automatic logic [2:0] corner_signs(input logic [2:0] face,
                                               input logic [1:0] corner);
      logic [11:0] row;
      unique case (face)
         3'd0:    row = {3'd7, 3'd5, 3'd4, 3'd6};
         3'd1:    row = {3'd3, 3'd2, 3'd0, 3'd1};
         3'd2:    row = {3'd6, 3'd2, 3'd3, 3'd7};
         3'd3:    row = {3'd5, 3'd1, 3'd0, 3'd4};
         3'd4:    row = {3'd7, 3'd3, 3'd1, 3'd5};
         3'd5:    row = {3'd4, 3'd0, 3'd2, 3'd6};
         default: row = 12'd0;
      endcase
      return row[corner*3 +: 3];
   endfunction

endpackage

`default_nettype wire

@@ hdl/vfcm_req_if.sv @@
// ----------------------------------------------------------------------------
// vfcm_req_if
// request channel: one cell command per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface vfcm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [3:0] cell_x;
   logic [3:0] cell_y;
   logic [5:0] cell_z;
   logic [1:0] cell_type;

   modport source (output valid, kind, cell_x, cell_y, cell_z, cell_type, input ready);
   modport sink   (input valid, kind, cell_x, cell_y, cell_z, cell_type, output ready);
endinterface

`default_nettype wire

@@ hdl/vfcm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// vfcm_rsp_if
// response channel: one mesh vertex per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface vfcm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] pos_x;
   logic signed [14:0] pos_y;
   logic signed [16:0] pos_z;
   logic [2:0]         face;
   logic [1:0]         corner;
   logic               tex_u;
   logic               tex_v;
   logic [18:0]        vertex_index;
   logic [2:0]         alpha;
   logic               last;

   modport source (output valid, pos_x, pos_y, pos_z, face, corner, tex_u, tex_v,
                   vertex_index, alpha, last, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, face, corner, tex_u, tex_v,
                   vertex_index, alpha, last, output ready);
endinterface

`default_nettype wire

@@ hdl/vfcm_ram.sv @@
// ----------------------------------------------------------------------------
// vfcm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module vfcm_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ hdl/vfcm_ctrl.sv @@
// ----------------------------------------------------------------------------
// vfcm_ctrl
// sequencer: clear sweep, neighbor reads and vertex emission
// ----------------------------------------------------------------------------
`default_nettype none

module vfcm_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire vfcm_pkg::vfcm_status_type status,
   output vfcm_pkg::vfcm_cmd_type         cmd,
   output logic                           req_ready
);
   import vfcm_pkg::*;

   vfcm_state_type state_ff, state_in;
   logic [2:0]     step_ff, step_in;
   logic [2:0]     face_ff, face_in;
   logic [1:0]     corner_ff, corner_in;
   logic           accept;
   logic           face_on;
   logic           no_more;

   assign accept  = status.req_valid && req_ready;
   assign face_on = status.exposed[face_ff];
   assign no_more = (status.exposed >> (face_ff + 3'd1)) == 6'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         step_ff   <= 3'd0;
         face_ff   <= 3'd0;
         corner_ff <= 2'd0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         face_ff   <= face_in;
         corner_ff <= corner_in;
      end
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      face_in   = face_ff;
      corner_in = corner_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            step_in = 3'd0;
            if (accept && status.req_kind == KIND_MESH && status.req_in_grid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            step_in = step_ff + 3'd1;
            if (step_ff == LAST_STEP) state_in = ST_WAIT;
         end
         ST_WAIT: state_in = ST_CHECK;
         ST_CHECK: begin
            face_in   = 3'd0;
            corner_in = 2'd0;
            if (!status.self_solid || status.exposed == 6'd0) state_in = ST_IDLE;
            else state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!face_on) begin
               face_in = face_ff + 3'd1;
            end else if (status.out_free) begin
               corner_in = corner_ff + 2'd1;
               if (corner_ff == 2'd3) begin
                  face_in = face_ff + 3'd1;
                  if (no_more) state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      cmd.rd_step = step_ff;
      cmd.face    = face_ff;
      cmd.corner  = corner_ff;
      cmd.last    = (corner_ff == 2'd3) && no_more;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_step = 1'b1;
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = accept;
            cmd.mem_write = accept && status.req_kind == KIND_WRITE && status.req_in_grid;
            cmd.cnt_clear = accept && status.req_kind == KIND_CLEAR;
         end
         ST_READ:  cmd.rd_issue = 1'b1;
         ST_WAIT:  ;
         ST_CHECK: ;
         ST_EMIT:  cmd.emit = face_on && status.out_free;
         default:  ;
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/vfcm_datapath.sv @@
// ----------------------------------------------------------------------------
// vfcm_datapath
// cell latch, neighbor address, exposure mask, vertex build and output beat
// ----------------------------------------------------------------------------
`default_nettype none

module vfcm_datapath #(
   parameter int GRID_XY = vfcm_pkg::GRID_XY_DEFAULT,
   parameter int GRID_Z  = vfcm_pkg::GRID_Z_DEFAULT,
   parameter int AW      = $clog2(GRID_XY * GRID_XY * GRID_Z)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire vfcm_pkg::vfcm_cmd_type cmd,
   output vfcm_pkg::vfcm_status_type   status,
   vfcm_req_if.sink                    req_if,
   vfcm_rsp_if.source                  rsp_if,
   input  wire logic                   csr_we,
   input  wire logic [10:0]            csr_wdata,
   output logic                        mem_we,
   output logic [AW-1:0]               mem_waddr,
   output logic [1:0]                  mem_wdata,
   output logic [AW-1:0]               mem_raddr,
   input  wire logic [1:0]             mem_rdata
);
   import vfcm_pkg::*;

   localparam int DEPTH = GRID_XY * GRID_XY * GRID_Z;
   localparam int PLANE = GRID_XY * GRID_XY;

   logic [10:0] size_ff;
   logic [AW-1:0] clr_addr_ff;
   logic [3:0]  x_ff, y_ff;
   logic [5:0]  z_ff;
   logic [19:0] base_x_ff, base_y_ff, base_z_ff;
   logic        rd_valid_ff, in_grid_ff;
   logic [2:0]  rd_step_ff;
   logic [1:0]  self_ff;
   logic [5:0]  exposed_ff;
   logic [18:0] counter_ff;
   logic        rsp_valid_ff;
   logic [14:0] pos_x_ff, pos_y_ff;
   logic [16:0] pos_z_ff;
   logic [2:0]  face_ff, alpha_ff;
   logic [1:0]  corner_ff;
   logic [18:0] vidx_ff;
   logic        last_ff;

   logic [8:0]  nx, ny, nz;
   logic        n_in_grid;
   logic [31:0] req_lin, rd_lin;
   logic [10:0] half;
   logic [2:0]  signs;
   logic [19:0] px, py, pz;

   // request side address and bounds
   assign req_lin = 32'(req_if.cell_x) + 32'(req_if.cell_y) * GRID_XY
                  + 32'(req_if.cell_z) * PLANE;
   assign status.req_in_grid = (9'(req_if.cell_x) < 9'(GRID_XY))
                            && (9'(req_if.cell_y) < 9'(GRID_XY))
                            && (9'(req_if.cell_z) < 9'(GRID_Z));
   assign status.req_valid = req_if.valid;
   assign status.req_kind  = req_if.kind;

   // neighbor of the step: step 0 is the cell itself, then faces in order
   always_comb begin
      nx = 9'(x_ff);
      ny = 9'(y_ff);
      nz = 9'(z_ff);
      case (cmd.rd_step)
         3'd1:    nz = 9'(z_ff) + 9'd1;
         3'd2:    nz = 9'(z_ff) - 9'd1;
         3'd3:    ny = 9'(y_ff) + 9'd1;
         3'd4:    ny = 9'(y_ff) - 9'd1;
         3'd5:    nx = 9'(x_ff) + 9'd1;
         3'd6:    nx = 9'(x_ff) - 9'd1;
         default: ;
      endcase
   end

   assign n_in_grid = (nx < 9'(GRID_XY)) && (ny < 9'(GRID_XY)) && (nz < 9'(GRID_Z));
   assign rd_lin    = 32'(nx) + 32'(ny) * GRID_XY + 32'(nz) * PLANE;

   assign mem_we    = cmd.clr_step || cmd.mem_write;
   assign mem_waddr = cmd.clr_step ? clr_addr_ff : AW'(req_lin);
   assign mem_wdata = cmd.clr_step ? 2'd0 : req_if.cell_type;
   assign mem_raddr = AW'(rd_lin);

   assign status.clr_last   = clr_addr_ff == AW'(DEPTH - 1);
   assign status.self_solid = self_ff != 2'd0;
   assign status.exposed    = exposed_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_if.ready;

   // corner position of the vertex being built
   assign half  = size_ff >> 1;
   assign signs = corner_signs(cmd.face, cmd.corner);
   assign px = signs[0] ? base_x_ff + 20'(half) : base_x_ff - 20'(half);
   assign py = signs[1] ? base_y_ff + 20'(half) : base_y_ff - 20'(half);
   assign pz = signs[2] ? base_z_ff + 20'(half) : base_z_ff - 20'(half);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= VOXEL_SIZE_RESET;
         clr_addr_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) size_ff <= csr_wdata;
         if (cmd.clr_step) clr_addr_ff <= clr_addr_ff + AW'(1);
         rd_valid_ff <= cmd.rd_issue;
         if (cmd.cnt_clear) counter_ff <= '0;
         else if (cmd.emit) counter_ff <= counter_ff + 19'd1;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= req_if.cell_x;
         y_ff <= req_if.cell_y;
         z_ff <= req_if.cell_z;
      end
      if (cmd.rd_issue && cmd.rd_step == 3'd0) begin
         base_x_ff <= 20'(x_ff) * 20'(size_ff);
         base_y_ff <= 20'(y_ff) * 20'(size_ff);
         base_z_ff <= 20'(z_ff) * 20'(size_ff);
      end
      rd_step_ff <= cmd.rd_step;
      in_grid_ff <= n_in_grid;
      if (rd_valid_ff) begin
         if (rd_step_ff == 3'd0) self_ff <= mem_rdata;
         else exposed_ff[rd_step_ff - 3'd1] <= !in_grid_ff || mem_rdata == 2'd0;
      end
      if (cmd.emit) begin
         pos_x_ff  <= px[14:0];
         pos_y_ff  <= py[14:0];
         pos_z_ff  <= pz[16:0];
         face_ff   <= cmd.face;
         corner_ff <= cmd.corner;
         vidx_ff   <= counter_ff;
         alpha_ff  <= (self_ff == 2'd1) ? 3'd1 : cmd.face;
         last_ff   <= cmd.last;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.pos_x        = pos_x_ff;
   assign rsp_if.pos_y        = pos_y_ff;
   assign rsp_if.pos_z        = pos_z_ff;
   assign rsp_if.face         = face_ff;
   assign rsp_if.corner       = corner_ff;
   assign rsp_if.tex_u        = corner_ff[1];
   assign rsp_if.tex_v        = corner_ff[1] ^ corner_ff[0];
   assign rsp_if.vertex_index = vidx_ff;
   assign rsp_if.alpha        = alpha_ff;
   assign rsp_if.last         = last_ff;

endmodule

`default_nettype wire

@@ hdl/voxel_face_culling_mesher_unit.sv @@
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher_unit
// voxel grid store with culled face meshing, one vertex per response beat
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  req_if   | in        | kind, cell_x, cell_y, cell_z, cell_type
//  rsp_if   | out       | pos_x/y/z, face, corner, tex_u/v, vertex_index, alpha, last
//  csr_*    | in        | voxel_size write, no read-back
//
//  write and counter-clear beats finish at acceptance, in the idle state
//  an in-grid mesh beat is followed by grid reads (cell plus six neighbors through
//  the single read port of the grid ram, with registered read data) and the
//  exposure check, then the vertices of the exposed faces are emitted one per
//  beat, closed faces skipped, up to 24 vertices
//  after reset a sweep over all GRID_XY*GRID_XY*GRID_Z cells (16384 by default)
//  zeroes the grid; no request beat is taken meanwhile
//  a stalled response holds emission; the next request is taken while the
//  final vertex still waits in the output register
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_face_culling_mesher_unit #(
   parameter int GRID_XY = vfcm_pkg::GRID_XY_DEFAULT,
   parameter int GRID_Z  = vfcm_pkg::GRID_Z_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   vfcm_req_if.sink         req_if,
   vfcm_rsp_if.source       rsp_if,
   input  wire logic        csr_we,
   input  wire logic [10:0] csr_wdata
);
   import vfcm_pkg::*;

   localparam int DEPTH = GRID_XY * GRID_XY * GRID_Z;
   localparam int AW    = $clog2(DEPTH);

   vfcm_cmd_type    cmd;
   vfcm_status_type status;

   // grid ram ports
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [1:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [1:0]    mem_rdata;

   // sequencer owns the request handshake
   vfcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_if.ready)
   );

   vfcm_datapath #(
      .GRID_XY (GRID_XY),
      .GRID_Z  (GRID_Z),
      .AW      (AW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // voxel type codes, 2 bits per cell
   vfcm_ram #(
      .WIDTH (2),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

`default_nettype wire

@@ hdl/vfcm_checker.sv @@
// ----------------------------------------------------------------------------
// vfcm_checker
// port level checks of the mesher, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module vfcm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_face,
   input wire logic [1:0]  rsp_corner,
   input wire logic        rsp_tex_u,
   input wire logic [18:0] rsp_vertex_index,
   input wire logic        rsp_last
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex_index)
                                  && $stable(rsp_face) && $stable(rsp_corner))
      else $error("response beat changed under stall");

   // the final vertex of a cell closes a face
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_corner == 2'd3)
      else $error("last vertex not on corner 3");

   // uv follows the corner number and the face code stays in range
   a_uv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tex_u == rsp_corner[1] && rsp_face <= 3'd5)
      else $error("bad uv or face on response");

   // reset starts the clear sweep with nothing shown
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

endmodule

bind voxel_face_culling_mesher_unit vfcm_checker u_vfcm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_face         (rsp_if.face),
   .rsp_corner       (rsp_if.corner),
   .rsp_tex_u        (rsp_if.tex_u),
   .rsp_vertex_index (rsp_if.vertex_index),
   .rsp_last         (rsp_if.last)
);

`default_nettype wire

@@ sim/voxel_face_culling_mesher_unit_tb.sv @@
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher_unit_tb
// self-checking bench: builds voxel scenes, meshes cells and checks every
// vertex beat against a shadow grid and vertex counter
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module voxel_face_culling_mesher_unit_tb;
   import vfcm_pkg::*;

   localparam int GXY    = 16;
   localparam int GZ     = 64;
   localparam int NCELLS = GXY * GXY * GZ;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] cell_x;
      logic [3:0] cell_y;
      logic [5:0] cell_z;
      logic [1:0] cell_type;
   } cell_cmd_t;

   typedef struct packed {
      logic [14:0] pos_x;
      logic [14:0] pos_y;
      logic [16:0] pos_z;
      logic [2:0]  face;
      logic [1:0]  corner;
      logic        tex_u;
      logic        tex_v;
      logic [18:0] vertex_index;
      logic [2:0]  alpha;
      logic        last;
   } vertex_t;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [10:0] csr_wdata;

   vfcm_req_if req_if ();
   vfcm_rsp_if rsp_if ();

   voxel_face_culling_mesher_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block state
   logic [1:0]  grid_shadow [NCELLS];
   logic [18:0] vertex_count;
   logic [10:0] voxel_size;

   cell_cmd_t cmd_queue [$];
   vertex_t   vertex_queue [$];
   int        error_count;
   bit        req_taken;

   // corner sign bits: bit0 +x, bit1 +y, bit2 +z
   logic [2:0] corner_tab [6][4] = '{'{6, 4, 5, 7}, '{1, 0, 2, 3}, '{7, 3, 2, 6},
                                     '{4, 0, 1, 5}, '{5, 1, 3, 7}, '{6, 2, 0, 4}};

   function automatic bit solid_at(int x, int y, int z);
      if (x < 0 || x >= GXY || y < 0 || y >= GXY || z < 0 || z >= GZ)
         return 0;
      return grid_shadow[x + y * GXY + z * GXY * GXY] != 0;
   endfunction

   function automatic logic [31:0] corner_coord(int c, bit plus);
      logic [31:0] base;
      base = c * voxel_size;
      return plus ? base + (voxel_size >> 1) : base - (voxel_size >> 1);
   endfunction

   // apply one accepted beat to the shadow state, queue the vertices it yields
   task automatic predict_mesh(cell_cmd_t c);
      int x, y, z, nfaces, n;
      bit open_face [6];
      logic [1:0] self;
      logic [2:0] s;
      logic [31:0] cx, cy, cz;
      vertex_t v;
      x = c.cell_x; y = c.cell_y; z = c.cell_z;
      nfaces = 0; n = 0;
      if (c.kind == KIND_CLEAR) begin
         vertex_count = '0;
         return;
      end
      if (c.kind != KIND_WRITE && c.kind != KIND_MESH) return;
      if (c.kind == KIND_WRITE) begin
         grid_shadow[x + y * GXY + z * GXY * GXY] = c.cell_type;
         return;
      end
      self = grid_shadow[x + y * GXY + z * GXY * GXY];
      if (self == 0) return;
      open_face[0] = !solid_at(x, y, z + 1);
      open_face[1] = !solid_at(x, y, z - 1);
      open_face[2] = !solid_at(x, y + 1, z);
      open_face[3] = !solid_at(x, y - 1, z);
      open_face[4] = !solid_at(x + 1, y, z);
      open_face[5] = !solid_at(x - 1, y, z);
      foreach (open_face[f]) nfaces += open_face[f];
      for (int f = 0; f < 6; f++) begin
         if (!open_face[f]) continue;
         for (int k = 0; k < 4; k++) begin
            s  = corner_tab[f][k];
            cx = corner_coord(x, s[0]);
            cy = corner_coord(y, s[1]);
            cz = corner_coord(z, s[2]);
            v.pos_x        = cx[14:0];
            v.pos_y        = cy[14:0];
            v.pos_z        = cz[16:0];
            v.face         = 3'(f);
            v.corner       = 2'(k);
            v.tex_u        = (k >= 2);
            v.tex_v        = (k == 1 || k == 2);
            v.vertex_index = 19'(vertex_count + n);
            v.alpha        = (self == 1) ? 3'd1 : 3'(f);
            v.last         = (n == nfaces * 4 - 1);
            vertex_queue.push_back(v);
            n++;
         end
      end
      vertex_count = 19'(vertex_count + n);
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // driver: one beat per queued command, random gap after each
   int send_gap;
   initial begin
      req_if.valid = 0; req_if.kind = '0; req_if.cell_x = '0;
      req_if.cell_y = '0; req_if.cell_z = '0; req_if.cell_type = '0;
      send_gap = 0;
      req_taken = 0;
   end
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 0;
      end else if (req_if.valid && !req_taken) begin
         // hold the beat until taken
      end else if (send_gap > 0) begin
         req_if.valid <= 0;
         send_gap <= send_gap - 1;
      end else if (cmd_queue.size() > 0) begin
         cell_cmd_t c;
         c = cmd_queue.pop_front();
         req_if.valid     <= 1;
         req_if.kind      <= c.kind;
         req_if.cell_x    <= c.cell_x;
         req_if.cell_y    <= c.cell_y;
         req_if.cell_z    <= c.cell_z;
         req_if.cell_type <= c.cell_type;
         send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end else begin
         req_if.valid <= 0;
      end
   end
   // predict on every accepted beat; req_taken tells the driver the beat is gone
   always @(posedge clock) begin
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready)
         predict_mesh(cell_cmd_t'{req_if.kind, req_if.cell_x, req_if.cell_y,
                                  req_if.cell_z, req_if.cell_type});
   end

   // monitor: random stalls on ready, check each vertex beat
   int stall_left;
   initial begin
      rsp_if.ready = 0;
      stall_left = 0;
   end
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready <= 0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_if.ready <= 1;
         if (rsp_if.valid && rsp_if.ready)
            stall_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      end
   end
   always @(posedge clock) begin
      vertex_t exp_v;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (vertex_queue.size() == 0) begin
            $error("vertex beat with nothing expected");
            error_count++;
         end else begin
            exp_v = vertex_queue.pop_front();
            if (rsp_if.pos_x !== exp_v.pos_x) begin
               $error("pos_x exp %0h got %0h", exp_v.pos_x, rsp_if.pos_x); error_count++;
            end
            if (rsp_if.pos_y !== exp_v.pos_y) begin
               $error("pos_y exp %0h got %0h", exp_v.pos_y, rsp_if.pos_y); error_count++;
            end
            if (rsp_if.pos_z !== exp_v.pos_z) begin
               $error("pos_z exp %0h got %0h", exp_v.pos_z, rsp_if.pos_z); error_count++;
            end
            if (rsp_if.face !== exp_v.face) begin
               $error("face exp %0d got %0d", exp_v.face, rsp_if.face); error_count++;
            end
            if (rsp_if.corner !== exp_v.corner) begin
               $error("corner exp %0d got %0d", exp_v.corner, rsp_if.corner);
               error_count++;
            end
            if (rsp_if.tex_u !== exp_v.tex_u) begin
               $error("tex_u exp %0d got %0d", exp_v.tex_u, rsp_if.tex_u); error_count++;
            end
            if (rsp_if.tex_v !== exp_v.tex_v) begin
               $error("tex_v exp %0d got %0d", exp_v.tex_v, rsp_if.tex_v); error_count++;
            end
            if (rsp_if.vertex_index !== exp_v.vertex_index) begin
               $error("vertex_index exp %0d got %0d", exp_v.vertex_index,
                      rsp_if.vertex_index);
               error_count++;
            end
            if (rsp_if.alpha !== exp_v.alpha) begin
               $error("alpha exp %0d got %0d", exp_v.alpha, rsp_if.alpha); error_count++;
            end
            if (rsp_if.last !== exp_v.last) begin
               $error("last exp %0d got %0d", exp_v.last, rsp_if.last); error_count++;
            end
         end
      end
   end

   function automatic cell_cmd_t mk(logic [1:0] k, int x, int y, int z, int t);
      return cell_cmd_t'{k, 4'(x), 4'(y), 6'(z), 2'(t)};
   endfunction

   // let everything drain, then allow the block to finish a silent beat
   task automatic wait_quiet();
      while (req_if.valid || cmd_queue.size() > 0 || vertex_queue.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_size(logic [10:0] sz);
      @(negedge clock);
      csr_we    <= 1;
      csr_wdata <= sz;
      @(negedge clock);
      csr_we    <= 0;
      voxel_size = sz;
   endtask

   // a small random cluster: cells of random type written, then meshed
   task automatic queue_cluster();
      int bx, by, bz;
      bx = $urandom_range(0, 15); by = $urandom_range(0, 15); bz = $urandom_range(0, 63);
      repeat ($urandom_range(3, 8))
         cmd_queue.push_back(mk(KIND_WRITE, bx + $urandom_range(0, 2) - 1,
                                by + $urandom_range(0, 2) - 1,
                                bz + $urandom_range(0, 2) - 1, $urandom_range(0, 3)));
      repeat ($urandom_range(2, 6))
         cmd_queue.push_back(mk(KIND_MESH, bx + $urandom_range(0, 2) - 1,
                                by + $urandom_range(0, 2) - 1,
                                bz + $urandom_range(0, 2) - 1, $urandom_range(0, 3)));
   endtask

   initial begin
      int sent;
      logic [10:0] sizes [4] = '{11'd2, 11'd1024, 11'd2047, 11'd37};
      error_count = 0;
      vertex_count = '0;
      voxel_size = VOXEL_SIZE_RESET;
      foreach (grid_shadow[i]) grid_shadow[i] = '0;
      csr_we = 0;
      csr_wdata = '0;
      reset = 1;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: corners of the grid, buried cell, type one, kind three, clear
      cmd_queue.push_back(mk(KIND_MESH, 0, 0, 0, 0));             // empty cell
      cmd_queue.push_back(mk(KIND_WRITE, 0, 0, 0, 1));
      cmd_queue.push_back(mk(KIND_MESH, 0, 0, 0, 0));
      cmd_queue.push_back(mk(KIND_WRITE, 15, 15, 63, 3));
      cmd_queue.push_back(mk(KIND_MESH, 15, 15, 63, 0));
      for (int f = 0; f < 7; f++) begin                             // buried cell
         cmd_queue.push_back(mk(KIND_WRITE, 5 + (f == 4) - (f == 5), 5 + (f == 2) - (f == 3),
                                9 + (f == 0) - (f == 1), 2));
      end
      cmd_queue.push_back(mk(KIND_MESH, 5, 5, 9, 0));
      cmd_queue.push_back(mk(KIND_MESH, 6, 5, 9, 0));
      cmd_queue.push_back(mk(2'd3, 1, 1, 1, 1));                    // unused kind
      cmd_queue.push_back(mk(KIND_CLEAR, 0, 0, 0, 0));
      cmd_queue.push_back(mk(KIND_MESH, 15, 15, 63, 0));
      cmd_queue.push_back(mk(KIND_WRITE, 15, 15, 63, 0));
      cmd_queue.push_back(mk(KIND_MESH, 15, 15, 63, 0));
      sent = cmd_queue.size();
      // sender holds off until every vertex is back
      wait_quiet();

      foreach (sizes[i]) begin
         write_size(sizes[i]);
         repeat (70) begin
            queue_cluster();
            if ($urandom_range(0, 15) == 0) cmd_queue.push_back(mk(KIND_CLEAR, 0, 0, 0, 0));
            if ($urandom_range(0, 15) == 0)
               cmd_queue.push_back(mk(2'($urandom_range(0, 3)), $urandom, $urandom,
                                      $urandom, $urandom));
            if (cmd_queue.size() + sent > (i + 1) * 60) break;
         end
         sent += cmd_queue.size();
         wait_quiet();
      end
      write_size(11'd100);
      repeat (3) queue_cluster();
      wait_quiet();

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ files.f @@
hdl/vfcm_pkg.sv
hdl/vfcm_req_if.sv
hdl/vfcm_rsp_if.sv
hdl/vfcm_ram.sv
hdl/vfcm_ctrl.sv
hdl/vfcm_datapath.sv
hdl/voxel_face_culling_mesher_unit.sv
hdl/vfcm_checker.sv
sim/voxel_face_culling_mesher_unit_tb.sv
